// ----- rtl/dtic_pkg.sv -----
// ----------------------------------------------------------------------------
// dtic_pkg: shared types, constants and calibration tables
// Payload structs for both channels, the queue item between front and back,
// and the Q16 calibration curves of the shelf distance sensors.
// ----------------------------------------------------------------------------
`default_nettype none

package dtic_pkg;

    localparam int DIST_W     = 16;
    localparam int SENSOR_W   = 3;
    localparam int LEN_W      = 8;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 8;
    localparam int DEPTH_W    = 8;
    localparam int OFFSET_W   = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 11;

    // Internal arithmetic widths.
    localparam int NEAR_DIST_W = 9;   // readings that reach the formula are at most 400
    localparam int SLOPE_W     = 13;
    localparam int E_W         = 23;
    localparam int BASE_W      = 13;
    localparam int NUM_W       = 30;
    localparam int REM_W       = 13;
    localparam int DIVIDEND_W  = 16;

    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 4;

    localparam logic [DIST_W-1:0]   FAR_LIMIT_MM = 16'd400;
    localparam logic [COUNT_W-1:0]  ERROR_BASE   = 8'd250;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = 8'd255;
    localparam logic [SENSOR_W-1:0] LAST_CURVE   = 3'd4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SHELF_DEPTH = 2'd0,
        CFG_DIST_OFFSET = 2'd1
    } dtic_cfg_index_t;

    typedef struct packed {
        logic [DIST_W-1:0]   distance_mm;
        logic [SENSOR_W-1:0] sensor_index;
        logic [LEN_W-1:0]    item_length;
        logic [STATUS_W-1:0] sensor_status;
    } dtic_in_t;

    typedef struct packed {
        logic [COUNT_W-1:0] item_count;
        logic               zero_length_flag;
    } dtic_out_t;

    // One classified reading as it waits between front and back.
    typedef struct packed {
        logic                     direct;      // result already known
        logic [COUNT_W-1:0]       direct_count;
        logic                     flag;
        logic signed [BASE_W-1:0] base;
        logic signed [E_W-1:0]    corr;
        logic [LEN_W-1:0]         len;
    } dtic_item_t;

    // Slope of each calibration curve in Q16.
    function automatic logic signed [SLOPE_W-1:0] slope_of(input logic [SENSOR_W-1:0] curve);
        logic signed [SLOPE_W-1:0] s;
        case (curve)
            3'd1:    s = 13'sd3821;
            3'd2:    s = -13'sd439;
            3'd3:    s = 13'sd1258;
            3'd4:    s = 13'sd1160;
            default: s = 13'sd2025;
        endcase
        return s;
    endfunction

    // Intercept of each calibration curve in Q16.
    function automatic logic signed [E_W-1:0] icept_of(input logic [SENSOR_W-1:0] curve);
        logic signed [E_W-1:0] b;
        case (curve)
            3'd1:    b = -23'sd2797535;
            3'd2:    b = -23'sd1511981;
            3'd3:    b = -23'sd1634796;
            3'd4:    b = -23'sd1706885;
            default: b = -23'sd2411921;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/distance_to_item_count.sv -----
// ----------------------------------------------------------------------------
// distance_to_item_count: shelf distance reading to product count
// Throughput: one reading per cycle while full is low; a back stage per quotient bit.
// Path: middle queue, back pipeline stages, result port; there a count waits for pop.
// Reset: rst_n clears all queues and the pipeline; both registers reset to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_to_item_count #(
    parameter int MID_DEPTH = dtic_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = dtic_pkg::OUT_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Reading channel: a transaction happens when push is high and full low.
    input  wire logic                              push,
    input  wire dtic_pkg::dtic_in_t                reading,
    output logic                                   full,
    // Result channel: a transaction happens when pop is high and empty low.
    input  wire logic                              pop,
    output dtic_pkg::dtic_out_t                    result,
    output logic                                   empty,
    // Configuration write channel.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [dtic_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [dtic_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import dtic_pkg::*;

    // Configuration registers. The user must write them only while idle; the block
    // does not enforce it. Writes are always accepted, with no datapath interlock.
    logic [DEPTH_W-1:0]  shelf_depth_reg, shelf_depth_next;
    logic [OFFSET_W-1:0] dist_offset_reg, dist_offset_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        shelf_depth_next = shelf_depth_reg;
        dist_offset_next = dist_offset_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SHELF_DEPTH: shelf_depth_next = cfg_data[DEPTH_W-1:0];
                CFG_DIST_OFFSET: dist_offset_next = cfg_data[OFFSET_W-1:0];
                default:         ;  // Writes to unknown indexes are dropped.
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shelf_depth_reg <= '0;
            dist_offset_reg <= '0;
        end
        else
        begin
            shelf_depth_reg <= shelf_depth_next;
            dist_offset_reg <= dist_offset_next;
        end
    end

    // The front classifies the reading combinationally and writes the
    // classified item straight into the middle queue, so a reading is taken
    // whenever that queue has room.
    dtic_item_t front_item;
    dtic_item_t mid_item;
    logic       mid_full;
    logic       mid_empty;
    logic       mid_pop;

    dtic_front u_front (
        .reading     (reading),
        .shelf_depth (shelf_depth_reg),
        .dist_offset (dist_offset_reg),
        .item        (front_item)
    );

    assign full = mid_full;

    dtic_fifo #(
        .DEPTH (MID_DEPTH),
        .WIDTH ($bits(dtic_item_t))
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_item),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_item),
        .empty (mid_empty)
    );

    // The back pipeline drains the middle queue one item per cycle and
    // stalls as a whole only when its last stage cannot enter the result queue.
    dtic_out_t back_result;
    logic      out_push;
    logic      out_full;

    dtic_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (mid_item),
        .item_empty  (mid_empty),
        .item_pop    (mid_pop),
        .result      (back_result),
        .result_push (out_push),
        .result_full (out_full)
    );

    // The result queue parts the pipeline from the consumer, so new readings
    // keep flowing while a finished count waits to be popped.
    dtic_fifo #(
        .DEPTH (OUT_DEPTH),
        .WIDTH ($bits(dtic_out_t))
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (back_result),
        .full  (out_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

    // The pipeline never offers a result that the result queue would drop.
    assert property (@(posedge clk) disable iff (!rst_n) out_push |-> !out_full)
        else $error("result pushed into a full queue");

    // The back never pulls from an empty middle queue.
    assert property (@(posedge clk) disable iff (!rst_n) mid_pop |-> !mid_empty)
        else $error("middle queue popped while empty");

    // A zero-length count is always forced to zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.zero_length_flag) |-> (result.item_count == '0))
        else $error("zero length flag with nonzero count");

endmodule

`default_nettype wire

// ----- rtl/dtic_fifo.sv -----
// ----------------------------------------------------------------------------
// dtic_fifo: small synchronous queue
// Register-array queue with a fill count; used between front and back and
// in front of the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module dtic_fifo #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == DEPTH_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dtic_front.sv -----
// ----------------------------------------------------------------------------
// dtic_front: reading classifier
// Sorts a reading into error, far, zero length or formula, and for the
// formula case forms the calibration term and the integer base.
// ----------------------------------------------------------------------------
`default_nettype none

module dtic_front (
    input  wire dtic_pkg::dtic_in_t              reading,
    input  wire logic [dtic_pkg::DEPTH_W-1:0]    shelf_depth,
    input  wire logic [dtic_pkg::OFFSET_W-1:0]   dist_offset,
    output dtic_pkg::dtic_item_t                 item
);
    import dtic_pkg::*;

    logic [NEAR_DIST_W-1:0]    dist9;
    logic [SENSOR_W-1:0]       curve;
    logic signed [SLOPE_W-1:0] slope;
    logic signed [E_W-1:0]     prod;
    logic [DEPTH_W+3:0]        depth10;
    logic signed [BASE_W:0]    base_wide;

    assign dist9   = reading.distance_mm[NEAR_DIST_W-1:0];
    assign curve   = (reading.sensor_index <= LAST_CURVE) ? reading.sensor_index : '0;
    assign slope   = slope_of(curve);
    assign prod    = $signed({1'b0, dist9}) * slope;
    assign depth10 = {shelf_depth, 3'b000} + {2'b00, shelf_depth, 1'b0};
    assign base_wide = $signed({2'b00, depth10})
                     + $signed({6'b0, reading.item_length})
                     - $signed({5'b0, dist9})
                     - $signed({{(BASE_W + 1 - OFFSET_W){dist_offset[OFFSET_W-1]}},
                                dist_offset});

    always_comb
    begin
        item.base = base_wide[BASE_W-1:0];
        item.corr = prod + icept_of(curve);
        item.len  = reading.item_length;
        item.direct       = 1'b1;
        item.direct_count = '0;
        item.flag         = 1'b0;
        if (reading.sensor_status != '0)
        begin
            if (reading.sensor_status inside {[3'd6:3'd7]})
            begin
                item.direct_count = COUNT_MAX;
            end
            else
            begin
                item.direct_count = ERROR_BASE + {5'b0, reading.sensor_status};
            end
        end
        else if (reading.distance_mm > FAR_LIMIT_MM)
        begin
            item.direct_count = '0;
        end
        else if (reading.item_length == '0)
        begin
            item.flag = 1'b1;
        end
        else
        begin
            item.direct = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dtic_back.sv -----
// ----------------------------------------------------------------------------
// dtic_back: count pipeline
// Builds the Q16 numerator, then divides by the item length one quotient
// bit per stage with saturation at 255.
// ----------------------------------------------------------------------------
`default_nettype none

module dtic_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dtic_pkg::dtic_item_t item,
    input  wire logic                 item_empty,
    output logic                      item_pop,
    output dtic_pkg::dtic_out_t       result,
    output logic                      result_push,
    input  wire logic                 result_full
);
    import dtic_pkg::*;

    localparam int STEPS = COUNT_W;

    typedef struct packed {
        logic               direct;
        logic [COUNT_W-1:0] count;
        logic               flag;
        logic               neg;
        logic               sat;
        logic [LEN_W-1:0]   len;
        logic [REM_W-1:0]   rem;
    } dtic_stage_t;

    dtic_stage_t            stage_reg  [STEPS+1];
    dtic_stage_t            stage_next [STEPS+1];
    logic [STEPS:0]         valid_reg;
    logic                   stall;
    logic signed [NUM_W-1:0] num;
    logic [DIVIDEND_W-1:0]  div_shift [STEPS+1];
    logic                   fits      [STEPS+1];

    assign stall       = valid_reg[STEPS] && result_full;
    assign item_pop    = !stall && !item_empty;
    assign result_push = valid_reg[STEPS] && !result_full;

    assign num = $signed({item.base[BASE_W-1], item.base, 16'b0})
               + $signed({{(NUM_W - E_W){item.corr[E_W-1]}}, item.corr});

    always_comb
    begin
        stage_next[0].direct = item.direct;
        stage_next[0].count  = item.direct_count;
        stage_next[0].flag   = item.flag;
        stage_next[0].neg    = num[NUM_W-1];
        stage_next[0].sat    = 1'b0;
        stage_next[0].len    = item.len;
        stage_next[0].rem    = num[NUM_W-2:16];
        div_shift[0] = '0;
        fits[0]      = 1'b0;
        // Stage k settles quotient bit STEPS-k by a compare and subtract.
        for (int k = 1; k <= STEPS; k++)
        begin
            stage_next[k] = stage_reg[k-1];
            div_shift[k]  = {{(DIVIDEND_W - LEN_W){1'b0}}, stage_reg[k-1].len} << (STEPS - k);
            fits[k]       = {{(DIVIDEND_W - REM_W){1'b0}}, stage_reg[k-1].rem} >= div_shift[k];
            if (k == 1)
            begin
                stage_next[k].sat = {{(DIVIDEND_W - REM_W){1'b0}}, stage_reg[k-1].rem}
                                  >= {stage_reg[k-1].len, {STEPS{1'b0}}};
                if (!stage_reg[k-1].direct)
                begin
                    stage_next[k].count = '0;
                end
            end
            if (!stage_reg[k-1].direct && fits[k])
            begin
                stage_next[k].rem = stage_reg[k-1].rem - div_shift[k][REM_W-1:0];
                stage_next[k].count[STEPS-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (!stall)
        begin
            valid_reg <= {valid_reg[STEPS-1:0], item_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            for (int k = 0; k <= STEPS; k++)
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    // The count of a direct item is kept in stage one instead of cleared.
    dtic_stage_t last;
    assign last = stage_reg[STEPS];

    always_comb
    begin
        result.zero_length_flag = last.flag;
        if (last.direct)
        begin
            result.item_count = last.count;
        end
        else if (last.neg)
        begin
            result.item_count = '0;
        end
        else if (last.sat)
        begin
            result.item_count = COUNT_MAX;
        end
        else
        begin
            result.item_count = last.count;
        end
    end

endmodule

`default_nettype wire
